/* hdl/duration_text_parser_defines.svh */
// Assertion macros for the duration text parser.
`ifndef DURATION_TEXT_PARSER_DEFINES_SVH
`define DURATION_TEXT_PARSER_DEFINES_SVH

`ifndef SYNTH
`define DTP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("duration_text_parser: check failed");
`define DTP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("duration_text_parser: check failed");
`else
`define DTP_ASSERT(lbl, clk, rst_n, prop)
`define DTP_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

/* hdl/dtp_pkg.sv */
`timescale 1ns / 1ps

package dtp_pkg;

	localparam int unsigned FD_W = 4;
	localparam logic [FD_W-1:0] MAX_FRAC_DIGITS = 4'd9;

	localparam int unsigned MULT_W = 12;
	localparam logic [MULT_W-1:0] MULT_MIN = 12'd60;
	localparam logic [MULT_W-1:0] MULT_HOUR = 12'd3600;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_H = 8'h68;
	localparam logic [7:0] CH_M = 8'h6D;
	localparam logic [7:0] CH_S = 8'h73;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_SYNTAX,
		ERR_DIGITS
	} err_t;

	typedef enum logic [2:0] {
		UNIT_NONE,
		UNIT_COMMA,
		UNIT_SEC,
		UNIT_MIN,
		UNIT_HOUR
	} unit_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_DIGIT_WHOLE,
		OP_DIGIT_FRAC,
		OP_MUL_WHOLE,
		OP_MUL_FRAC,
		OP_DIV_STEP,
		OP_ACCUM,
		OP_ADD_WHOLE,
		OP_LOAD_OUT
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_FRAC,
		ST_DIV,
		ST_ACCUM,
		ST_FINISH
	} state_t;

	typedef struct packed {
		op_t  op;
		logic mult_hour;
		err_t out_status;
	} cmd_t;

	typedef struct packed {
		logic whole_zero;
		logic frac_zero;
		logic fd_max;
		logic out_free;
	} stat_t;

	function automatic logic [31:0] pow10(input logic [FD_W-1:0] n);
		logic [31:0] r;
		case (n)
			4'd0: r = 32'd1;
			4'd1: r = 32'd10;
			4'd2: r = 32'd100;
			4'd3: r = 32'd1000;
			4'd4: r = 32'd10000;
			4'd5: r = 32'd100000;
			4'd6: r = 32'd1000000;
			4'd7: r = 32'd10000000;
			4'd8: r = 32'd100000000;
			4'd9: r = 32'd1000000000;
			default: r = 32'd1;
		endcase
		return r;
	endfunction

endpackage

/* hdl/duration_text_parser.sv */
`timescale 1ns / 1ps
// Duration text parser.
// Input channel (in_valid/in_ready): one word per byte of duration text in
// character, or a terminator word with end_mark set, whose character is ignored.
// Output channel (out_valid/out_ready): one word per terminator, carrying
// status (0 valid, 1 syntax error, 2 too many fraction digits) and seconds.
// Handling: digits, '.', 's' and bytes after an error are taken in the idle
// state. 'h', 'm' and ',' pass through a product with the unit multiplier,
// then a 32-step restoring divider that scales the fraction, one quotient bit
// per cycle. A terminator after a bare minute count also runs that divider
// before its result is loaded; any other terminator goes straight to the load.
// The result sits in an output register, so text for the next duration is
// accepted while it waits. A terminator that meets a full, stalled output
// register holds the input side until the receiver takes the earlier word.
// Reset clears the parse state and drops any pending result.

`include "duration_text_parser_defines.svh"

module duration_text_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  character,
	input  logic        end_mark,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] seconds
);

	dtp_pkg::cmd_t  cmd;
	dtp_pkg::stat_t stat;

	dtp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.character (character),
		.end_mark  (end_mark),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	dtp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.digit     (character[3:0]),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.status    (status),
		.seconds   (seconds)
	);

	`DTP_ASSERT(a_err_zero_secs, clk, arst_n, !(out_valid && status != dtp_pkg::ERR_NONE) || seconds == 32'd0)
	`DTP_ASSERT_NEXT(a_end_busy, clk, arst_n, in_valid && in_ready && end_mark, !in_ready)
	`DTP_ASSERT(a_load_when_busy, clk, arst_n, !$rose(out_valid) || $past(!in_ready))

endmodule

/* hdl/dtp_datapath.sv */
`timescale 1ns / 1ps

module dtp_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  dtp_pkg::cmd_t       cmd,
	input  logic [3:0]          digit,
	output dtp_pkg::stat_t      stat,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [1:0]          status,
	output logic [31:0]         seconds
);

	logic [31:0] whole_q, frac_q, total_q;
	logic [dtp_pkg::FD_W-1:0] fd_q;
	logic [31:0] prod_q, quot_q, rem_q, div_q;
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [31:0] seconds_q;

	logic [31:0] mul_a;
	logic [dtp_pkg::MULT_W-1:0] mul_k;
	logic [31+dtp_pkg::MULT_W:0] mul_full;
	logic [32:0] rem_sh, diff;

	assign mul_a = (cmd.op == dtp_pkg::OP_MUL_FRAC) ? frac_q : whole_q;
	assign mul_k = cmd.mult_hour ? dtp_pkg::MULT_HOUR : dtp_pkg::MULT_MIN;
	assign mul_full = {{dtp_pkg::MULT_W{1'b0}}, mul_a} * {32'd0, mul_k};

	assign rem_sh = {rem_q, quot_q[31]};
	assign diff = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_q <= '0;
			frac_q <= '0;
			total_q <= '0;
			fd_q <= '0;
		end else begin
			case (cmd.op)
				dtp_pkg::OP_DIGIT_WHOLE: begin
					whole_q <= {whole_q[28:0], 3'b000} + {whole_q[30:0], 1'b0} + {28'd0, digit};
				end
				dtp_pkg::OP_DIGIT_FRAC: begin
					frac_q <= {frac_q[28:0], 3'b000} + {frac_q[30:0], 1'b0} + {28'd0, digit};
					fd_q <= fd_q + 4'd1;
				end
				dtp_pkg::OP_ACCUM: begin
					total_q <= total_q + prod_q + quot_q;
					whole_q <= '0;
					frac_q <= '0;
				end
				dtp_pkg::OP_ADD_WHOLE: begin
					total_q <= total_q + whole_q;
					whole_q <= '0;
				end
				dtp_pkg::OP_LOAD_OUT: begin
					total_q <= '0;
					whole_q <= '0;
					frac_q <= '0;
					fd_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			dtp_pkg::OP_MUL_WHOLE: begin
				prod_q <= mul_full[31:0];
			end
			dtp_pkg::OP_MUL_FRAC: begin
				quot_q <= mul_full[31:0];
				rem_q <= '0;
				div_q <= dtp_pkg::pow10(fd_q);
			end
			dtp_pkg::OP_DIV_STEP: begin
				if (!diff[32]) begin
					rem_q <= diff[31:0];
					quot_q <= {quot_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh[31:0];
					quot_q <= {quot_q[30:0], 1'b0};
				end
			end
			dtp_pkg::OP_LOAD_OUT: begin
				status_q <= cmd.out_status;
				seconds_q <= (cmd.out_status == dtp_pkg::ERR_NONE) ? total_q : 32'd0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == dtp_pkg::OP_LOAD_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.whole_zero = (whole_q == 32'd0);
	assign stat.frac_zero = (frac_q == 32'd0);
	assign stat.fd_max = (fd_q >= dtp_pkg::MAX_FRAC_DIGITS);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign seconds = seconds_q;

endmodule

/* hdl/dtp_ctrl.sv */
`timescale 1ns / 1ps

module dtp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [7:0]     character,
	input  logic           end_mark,
	output logic           in_ready,
	output dtp_pkg::cmd_t  cmd,
	input  dtp_pkg::stat_t stat
);

	dtp_pkg::state_t state_q, state_n;
	dtp_pkg::unit_t  last_unit_q, last_unit_n;
	dtp_pkg::err_t   err_q, err_n;
	dtp_pkg::err_t   fin_q, fin_n;
	logic            in_frac_q, in_frac_n;
	logic            end_q, end_n;
	logic            hour_q, hour_n;
	logic [4:0]      cnt_q, cnt_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtp_pkg::ST_IDLE;
			last_unit_q <= dtp_pkg::UNIT_NONE;
			err_q <= dtp_pkg::ERR_NONE;
			fin_q <= dtp_pkg::ERR_NONE;
			in_frac_q <= 1'b0;
			end_q <= 1'b0;
			hour_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_n;
			last_unit_q <= last_unit_n;
			err_q <= err_n;
			fin_q <= fin_n;
			in_frac_q <= in_frac_n;
			end_q <= end_n;
			hour_q <= hour_n;
			cnt_q <= cnt_n;
		end
	end

	always_comb begin
		state_n = state_q;
		last_unit_n = last_unit_q;
		err_n = err_q;
		fin_n = fin_q;
		in_frac_n = in_frac_q;
		end_n = end_q;
		hour_n = hour_q;
		cnt_n = cnt_q;
		in_ready = 1'b0;
		cmd.op = dtp_pkg::OP_NOP;
		cmd.mult_hour = hour_q;
		cmd.out_status = fin_q;
		case (state_q)
			dtp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && end_mark) begin
					state_n = dtp_pkg::ST_FINISH;
					if (err_q != dtp_pkg::ERR_NONE) begin
						fin_n = err_q;
					end else begin
						case (last_unit_q)
							dtp_pkg::UNIT_NONE: begin
								cmd.op = dtp_pkg::OP_MUL_WHOLE;
								cmd.mult_hour = 1'b0;
								hour_n = 1'b0;
								end_n = 1'b1;
								fin_n = dtp_pkg::ERR_NONE;
								state_n = dtp_pkg::ST_MUL_FRAC;
							end
							dtp_pkg::UNIT_COMMA: begin
								if (in_frac_q) begin
									fin_n = dtp_pkg::ERR_SYNTAX;
								end else begin
									cmd.op = dtp_pkg::OP_ADD_WHOLE;
									fin_n = dtp_pkg::ERR_NONE;
								end
							end
							default: begin
								fin_n = (stat.whole_zero && stat.frac_zero) ?
									dtp_pkg::ERR_NONE : dtp_pkg::ERR_SYNTAX;
							end
						endcase
					end
				end else if (in_valid && err_q == dtp_pkg::ERR_NONE) begin
					case (character)
						dtp_pkg::CH_DOT: begin
							if (in_frac_q) begin
								err_n = dtp_pkg::ERR_SYNTAX;
							end else begin
								in_frac_n = 1'b1;
							end
						end
						dtp_pkg::CH_COMMA, dtp_pkg::CH_H: begin
							if (last_unit_q != dtp_pkg::UNIT_NONE) begin
								err_n = dtp_pkg::ERR_SYNTAX;
							end else begin
								in_frac_n = 1'b0;
								last_unit_n = (character == dtp_pkg::CH_H) ?
									dtp_pkg::UNIT_HOUR : dtp_pkg::UNIT_COMMA;
								hour_n = (character == dtp_pkg::CH_H);
								cmd.mult_hour = (character == dtp_pkg::CH_H);
								cmd.op = dtp_pkg::OP_MUL_WHOLE;
								state_n = dtp_pkg::ST_MUL_FRAC;
							end
						end
						dtp_pkg::CH_M: begin
							if (last_unit_q == dtp_pkg::UNIT_COMMA ||
								last_unit_q == dtp_pkg::UNIT_MIN ||
								last_unit_q == dtp_pkg::UNIT_SEC) begin
								err_n = dtp_pkg::ERR_SYNTAX;
							end else begin
								in_frac_n = 1'b0;
								last_unit_n = dtp_pkg::UNIT_MIN;
								hour_n = 1'b0;
								cmd.mult_hour = 1'b0;
								cmd.op = dtp_pkg::OP_MUL_WHOLE;
								state_n = dtp_pkg::ST_MUL_FRAC;
							end
						end
						dtp_pkg::CH_S: begin
							if (last_unit_q == dtp_pkg::UNIT_COMMA ||
								last_unit_q == dtp_pkg::UNIT_SEC || in_frac_q) begin
								err_n = dtp_pkg::ERR_SYNTAX;
							end else begin
								last_unit_n = dtp_pkg::UNIT_SEC;
								cmd.op = dtp_pkg::OP_ADD_WHOLE;
							end
						end
						default: begin
							if (character >= dtp_pkg::CH_ZERO && character <= dtp_pkg::CH_NINE) begin
								if (!in_frac_q) begin
									cmd.op = dtp_pkg::OP_DIGIT_WHOLE;
								end else if (stat.fd_max) begin
									err_n = dtp_pkg::ERR_DIGITS;
								end else begin
									cmd.op = dtp_pkg::OP_DIGIT_FRAC;
								end
							end else begin
								err_n = dtp_pkg::ERR_SYNTAX;
							end
						end
					endcase
				end
			end
			dtp_pkg::ST_MUL_FRAC: begin
				cmd.op = dtp_pkg::OP_MUL_FRAC;
				cnt_n = '0;
				state_n = dtp_pkg::ST_DIV;
			end
			dtp_pkg::ST_DIV: begin
				cmd.op = dtp_pkg::OP_DIV_STEP;
				cnt_n = cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					state_n = dtp_pkg::ST_ACCUM;
				end
			end
			dtp_pkg::ST_ACCUM: begin
				cmd.op = dtp_pkg::OP_ACCUM;
				state_n = end_q ? dtp_pkg::ST_FINISH : dtp_pkg::ST_IDLE;
			end
			dtp_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					cmd.op = dtp_pkg::OP_LOAD_OUT;
					state_n = dtp_pkg::ST_IDLE;
					last_unit_n = dtp_pkg::UNIT_NONE;
					err_n = dtp_pkg::ERR_NONE;
					in_frac_n = 1'b0;
					end_n = 1'b0;
				end
			end
			default: begin
				state_n = dtp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* tb/duration_text_parser_checker.sv */
`timescale 1ns / 1ps

module duration_text_parser_checker import dtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  character,
	input  logic        end_mark,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [31:0] seconds,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		err_t        code;
		logic [31:0] secs;
	} duration_result_t;

	duration_result_t expected_durations[$];
	duration_result_t oldest;

	unit_t           unit_seen = UNIT_NONE;
	logic            frac_active = 1'b0;
	logic [31:0]     whole_acc = '0;
	logic [31:0]     frac_acc = '0;
	logic [FD_W-1:0] frac_count = '0;
	logic [31:0]     secs_total = '0;
	err_t            err_seen = ERR_NONE;

	int mismatch_count = 0;
	int expected_count = 0;

	assign fail_count = mismatch_count;
	assign pending = expected_count;

	function automatic logic [31:0] ten_power(input logic [FD_W-1:0] n);
		logic [31:0] p;
		int i;
		p = 32'd1;
		for (i = 0; i < n; i++)
			p = p * 32'd10;
		return p;
	endfunction

	task automatic clear_parse();
		unit_seen = UNIT_NONE;
		frac_active = 1'b0;
		whole_acc = '0;
		frac_acc = '0;
		frac_count = '0;
		secs_total = '0;
		err_seen = ERR_NONE;
	endtask

	task automatic fold_part(input logic [31:0] mult);
		logic [31:0] whole_prod;
		logic [31:0] frac_prod;
		logic [31:0] frac_secs;
		whole_prod = mult * whole_acc;
		frac_prod = mult * frac_acc;
		frac_secs = frac_prod / ten_power(frac_count);
		secs_total = secs_total + whole_prod + frac_secs;
		whole_acc = '0;
		frac_acc = '0;
	endtask

	task automatic take_byte(input logic [7:0] c);
		logic [31:0] digit;
		digit = {24'd0, c - CH_ZERO};
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (frac_active) begin
				if (frac_count >= MAX_FRAC_DIGITS) begin
					err_seen = ERR_DIGITS;
				end else begin
					frac_acc = 32'd10 * frac_acc + digit;
					frac_count = frac_count + 1'b1;
				end
			end else begin
				whole_acc = 32'd10 * whole_acc + digit;
			end
		end else begin
			case (c)
				CH_DOT: begin
					if (frac_active)
						err_seen = ERR_SYNTAX;
					else
						frac_active = 1'b1;
				end
				CH_COMMA: begin
					if (unit_seen != UNIT_NONE) begin
						err_seen = ERR_SYNTAX;
					end else begin
						frac_active = 1'b0;
						unit_seen = UNIT_COMMA;
						fold_part({20'd0, MULT_MIN});
					end
				end
				CH_H: begin
					if (unit_seen != UNIT_NONE) begin
						err_seen = ERR_SYNTAX;
					end else begin
						frac_active = 1'b0;
						unit_seen = UNIT_HOUR;
						fold_part({20'd0, MULT_HOUR});
					end
				end
				CH_M: begin
					if (unit_seen == UNIT_COMMA || unit_seen == UNIT_MIN
							|| unit_seen == UNIT_SEC) begin
						err_seen = ERR_SYNTAX;
					end else begin
						frac_active = 1'b0;
						unit_seen = UNIT_MIN;
						fold_part({20'd0, MULT_MIN});
					end
				end
				CH_S: begin
					if (unit_seen == UNIT_COMMA || unit_seen == UNIT_SEC || frac_active) begin
						err_seen = ERR_SYNTAX;
					end else begin
						unit_seen = UNIT_SEC;
						secs_total = secs_total + whole_acc;
						whole_acc = '0;
					end
				end
				default: err_seen = ERR_SYNTAX;
			endcase
		end
	endtask

	task automatic finish_duration();
		duration_result_t r;
		logic [31:0] min_whole;
		logic [31:0] min_frac;
		r.secs = '0;
		if (err_seen == ERR_NONE) begin
			if (unit_seen == UNIT_NONE) begin
				min_whole = {20'd0, MULT_MIN} * whole_acc;
				min_frac = {20'd0, MULT_MIN} * frac_acc;
				r.secs = min_whole + min_frac / ten_power(frac_count);
			end else if (unit_seen == UNIT_COMMA) begin
				if (frac_active)
					err_seen = ERR_SYNTAX;
				else
					r.secs = secs_total + whole_acc;
			end else begin
				if (whole_acc != 0 || frac_acc != 0)
					err_seen = ERR_SYNTAX;
				else
					r.secs = secs_total;
			end
		end
		r.code = err_seen;
		if (err_seen != ERR_NONE)
			r.secs = '0;
		expected_durations.push_back(r);
		clear_parse();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			expected_durations.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_durations.size() == 0) begin
					$error("result word with none expected: status %0d seconds %0d",
						status, seconds);
					mismatch_count++;
				end else begin
					oldest = expected_durations.pop_front();
					if (status !== oldest.code) begin
						$error("status: expected %0d, actual %0d", oldest.code, status);
						mismatch_count++;
					end
					if (seconds !== oldest.secs) begin
						$error("seconds: expected %0d, actual %0d", oldest.secs, seconds);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (end_mark)
					finish_duration();
				else if (err_seen == ERR_NONE)
					take_byte(character);
			end
		end
		expected_count = expected_durations.size();
	end

endmodule

/* tb/duration_text_parser_tb.sv */
`timescale 1ns / 1ps

module duration_text_parser_tb;
	import dtp_pkg::*;

	localparam int RANDOM_WORDS = 850;
	localparam int CALM_WORDS = 100;
	localparam int HOLD_OFFSET = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int PAUSE_OFFSET = 550;
	localparam int TAIL_CYCLES = 50;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct {
		logic [7:0] ch;
		logic       fin;
	} text_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  character = '0;
	logic        end_mark = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [31:0] seconds;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int sent_count = 0;
	int directed_len = 0;
	bit calm = 1'b0;
	bit hold_done = 1'b0;

	text_word_t text_words[$];

	always #5 clk = ~clk;

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	duration_text_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.character (character),
		.end_mark  (end_mark),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.seconds   (seconds)
	);

	duration_text_parser_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.character  (character),
		.end_mark   (end_mark),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.seconds    (seconds),
		.fail_count (fail_count),
		.pending    (pending)
	);

	task automatic plan_byte(input logic [7:0] c);
		text_word_t w;
		w.ch = c;
		w.fin = 1'b0;
		text_words.push_back(w);
	endtask

	task automatic plan_end();
		text_word_t w;
		w.ch = 8'($urandom_range(0, 255));
		w.fin = 1'b1;
		text_words.push_back(w);
	endtask

	task automatic plan_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			plan_byte(s[i]);
	endtask

	task automatic plan_digits(input bit allow_empty);
		int n;
		int lo;
		lo = allow_empty ? 0 : 1;
		if ($urandom_range(0, 7) == 0)
			n = $urandom_range(6, 12);
		else
			n = $urandom_range(lo, 4);
		repeat (n)
			plan_byte(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic plan_tagged_part(input logic [7:0] unit_char, input bit with_frac);
		plan_digits(1'b0);
		if (with_frac && $urandom_range(0, 2) == 0) begin
			plan_byte(CH_DOT);
			plan_digits(1'b1);
		end
		plan_byte(unit_char);
	endtask

	task automatic plan_valid_duration();
		if ($urandom_range(0, 2) == 0) begin
			plan_digits(1'b1);
			if ($urandom_range(0, 1) == 0) begin
				plan_byte(CH_DOT);
				plan_digits(1'b1);
			end
			if ($urandom_range(0, 1) == 0) begin
				plan_byte(CH_COMMA);
				plan_digits(1'b1);
			end
		end else begin
			if ($urandom_range(0, 1) == 0)
				plan_tagged_part(CH_H, 1'b1);
			if ($urandom_range(0, 1) == 0)
				plan_tagged_part(CH_M, 1'b1);
			if ($urandom_range(0, 1) == 0)
				plan_tagged_part(CH_S, 1'b0);
			if ($urandom_range(0, 7) == 0)
				plan_digits(1'b0);
		end
		plan_end();
	endtask

	task automatic plan_noisy_duration();
		string alphabet;
		alphabet = "0123456789.,hms";
		repeat ($urandom_range(0, 8)) begin
			if ($urandom_range(0, 4) < 3)
				plan_byte(alphabet[$urandom_range(0, 14)]);
			else
				plan_byte(8'($urandom_range(0, 255)));
		end
		plan_end();
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		@(posedge clk iff cycle_count == CYCLE_LIMIT);
		$display("FAIL duration_text_parser");
		$finish;
	end

	initial begin
		forever begin
			if (!hold_done && sent_count >= directed_len + HOLD_OFFSET && directed_len > 0) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && arst_n && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		text_word_t w;
		int total;
		int i;

		text_words.push_back('{8'hFF, 1'b1});
		plan_byte(8'h00);
		plan_end();
		plan_text("1.5h2m");
		plan_end();
		plan_text("3,7");
		plan_end();
		plan_text("4s");
		plan_end();
		plan_text(".9999999999x");
		plan_end();
		directed_len = text_words.size();
		while (text_words.size() < directed_len + RANDOM_WORDS) begin
			if ($urandom_range(0, 3) == 0)
				plan_noisy_duration();
			else
				plan_valid_duration();
		end
		total = text_words.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < total; i++) begin
			w = text_words[i];
			if (i == directed_len || i == directed_len + PAUSE_OFFSET)
				wait_drained();
			else if (!calm && $urandom_range(0, 3) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			if (i >= total - CALM_WORDS)
				calm = 1'b1;
			in_valid <= 1'b1;
			character <= w.ch;
			end_mark <= w.fin;
			do
				@(posedge clk);
			while (!in_ready);
			sent_count = i + 1;
		end
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("PASS duration_text_parser");
		else
			$display("FAIL duration_text_parser");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/dtp_pkg.sv
hdl/dtp_datapath.sv
hdl/dtp_ctrl.sv
hdl/duration_text_parser.sv
tb/duration_text_parser_checker.sv
tb/duration_text_parser_tb.sv
